[sv/sixel_stream_decoder_defines.svh]
// ----------------------------------------------------------------------------
// Sixel stream decoder assertion macros
// Shared property wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SIXEL_STREAM_DECODER_DEFINES_SVH
`define SIXEL_STREAM_DECODER_DEFINES_SVH

// same-cycle implication
`define SXD_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SXD_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sxd_pkg.sv]
// ----------------------------------------------------------------------------
// Sixel stream decoder package
// Payload types, result kinds and parser phases.
// ----------------------------------------------------------------------------
package sxd_pkg;

  localparam int VALUE_BITS = 16;
  localparam int FIFO_DEPTH = 4;

  typedef logic [VALUE_BITS-1:0] val_t;

  localparam logic [2:0] K_SIZE  = 3'd0;
  localparam logic [2:0] K_PAL   = 3'd1;
  localparam logic [2:0] K_WRITE = 3'd2;
  localparam logic [2:0] K_DONE  = 3'd3;
  localparam logic [2:0] K_FAIL  = 3'd4;

  typedef struct packed {
    logic [7:0] byte_in;
    logic       stream_end;
  } in_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic        last;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [5:0]  mask;
    logic [15:0] run_length;
    logic [15:0] color_index;
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [15:0] width;
    logic [15:0] height;
  } out_t;

  typedef struct packed {
    logic [2:0] count;
  } fifo_stat_t;

  typedef enum logic [10:0] {
    PH_WAIT_ESC = 11'b000_0000_0001,
    PH_WAIT_P   = 11'b000_0000_0010,
    PH_PAR_ANY  = 11'b000_0000_0100,
    PH_PAR_SEP  = 11'b000_0000_1000,
    PH_HEADER   = 11'b000_0001_0000,
    PH_GROUP    = 11'b000_0010_0000,
    PH_BODY     = 11'b000_0100_0000,
    PH_BODY_ESC = 11'b000_1000_0000,
    PH_REPEAT   = 11'b001_0000_0000,
    PH_SELECT   = 11'b010_0000_0000,
    PH_HALT     = 11'b100_0000_0000
  } phase_t;

  localparam logic [7:0] CH_ESC   = 8'h1b;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_Q     = 8'h71;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_DOLL  = 8'h24;
  localparam logic [7:0] CH_DASH  = 8'h2d;
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] DATA_LO  = 8'h3f;
  localparam logic [7:0] DATA_HI  = 8'h7e;
  localparam int         BAND_H   = 6;

endpackage

[sv/sxd_core.sv]
// ----------------------------------------------------------------------------
// Sixel parser core
// Parser state and one-byte decode; emits up to two results per request.
// ----------------------------------------------------------------------------
module sxd_core import sxd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  in_t        in_data,
  output logic [1:0] res_n,
  output out_t       res0,
  output out_t       res1
);

  localparam logic [VALUE_BITS-1:0] VMAX = {VALUE_BITS{1'b1}};

  phase_t     phase_r, phase_nxt;
  val_t       acc_r, acc_nxt;
  logic       seen_r, seen_nxt;
  logic       isc_r, isc_nxt;
  logic [2:0] gcnt_r, gcnt_nxt;
  val_t       gv_r [3];
  val_t       gv_nxt [3];
  val_t       cx_r, cx_nxt;
  val_t       by_r, by_nxt;
  val_t       cc_r, cc_nxt;
  val_t       pc_r, pc_nxt;

  logic [7:0]            b;
  logic                  is_dig, is_dat;
  logic [VALUE_BITS+3:0] acc_wide;
  val_t                  acc_dig;
  logic                  do_close, do_hdr, do_body, do_wr;
  logic                  ga, ma;
  out_t                  rg, rm;
  val_t                  run;
  logic [VALUE_BITS:0]   sum;

  assign b      = in_data.byte_in;
  assign is_dig = (b >= CH_ZERO) && (b <= CH_NINE);
  assign is_dat = (b >= DATA_LO) && (b <= DATA_HI);

  // acc * 10 + digit, saturating
  assign acc_wide = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1)
                  + {{(VALUE_BITS){1'b0}}, 4'(b - CH_ZERO)};
  assign acc_dig  = (acc_wide[VALUE_BITS+3:VALUE_BITS] != 4'd0) ? VMAX
                  : acc_wide[VALUE_BITS-1:0];

  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    seen_nxt  = seen_r;
    isc_nxt   = isc_r;
    gcnt_nxt  = gcnt_r;
    gv_nxt    = gv_r;
    cx_nxt    = cx_r;
    by_nxt    = by_r;
    cc_nxt    = cc_r;
    pc_nxt    = pc_r;
    do_close  = 1'b0;
    do_hdr    = 1'b0;
    do_body   = 1'b0;
    do_wr     = 1'b0;
    ga        = 1'b0;
    ma        = 1'b0;
    rg        = '0;
    rm        = '0;
    run       = val_t'(1);
    sum       = '0;

    if (in_data.stream_end) begin
      case (phase_r)
        PH_WAIT_ESC, PH_WAIT_P, PH_PAR_ANY, PH_PAR_SEP, PH_BODY_ESC: begin
          ma = 1'b1; rm.kind = K_FAIL; phase_nxt = PH_HALT;
        end
        PH_GROUP: do_close = 1'b1;
        PH_HEADER, PH_BODY, PH_REPEAT, PH_SELECT: begin
          ma = 1'b1; rm.kind = K_DONE; phase_nxt = PH_HALT;
        end
        default: ;
      endcase
    end else begin
      case (phase_r)
        PH_WAIT_ESC: begin
          if (b == CH_ESC) phase_nxt = PH_WAIT_P;
          else begin ma = 1'b1; rm.kind = K_FAIL; phase_nxt = PH_HALT; end
        end
        PH_WAIT_P: begin
          if (b == CH_P) phase_nxt = PH_PAR_ANY;
          else begin ma = 1'b1; rm.kind = K_FAIL; phase_nxt = PH_HALT; end
        end
        PH_PAR_ANY: phase_nxt = (b == CH_Q) ? PH_HEADER : PH_PAR_SEP;
        PH_PAR_SEP: begin
          if (b == CH_SEMI) phase_nxt = PH_PAR_ANY;
          else if (b == CH_Q) phase_nxt = PH_HEADER;
          else begin ma = 1'b1; rm.kind = K_FAIL; phase_nxt = PH_HALT; end
        end
        PH_HEADER: do_hdr = 1'b1;
        PH_GROUP: begin
          if (is_dig) begin
            acc_nxt = acc_dig; seen_nxt = 1'b1;
          end else if (b == CH_SEMI && seen_r) begin
            if (gcnt_r >= 3'd2 && gcnt_r <= 3'd4) gv_nxt[2'(gcnt_r - 3'd2)] = acc_r;
            if (gcnt_r != 3'd7) gcnt_nxt = gcnt_r + 3'd1;
            acc_nxt = '0; seen_nxt = 1'b0;
          end else begin
            do_close = 1'b1; do_hdr = 1'b1;
          end
        end
        PH_BODY: do_body = 1'b1;
        PH_BODY_ESC: begin
          ma = 1'b1; rm.kind = (b == CH_BSL) ? K_DONE : K_FAIL; phase_nxt = PH_HALT;
        end
        PH_REPEAT: begin
          if (is_dig) begin
            acc_nxt = acc_dig; seen_nxt = 1'b1;
          end else if (!seen_r || !is_dat) begin
            ma = 1'b1; rm.kind = K_DONE; phase_nxt = PH_HALT;
          end else begin
            run = acc_r; acc_nxt = '0; seen_nxt = 1'b0;
            phase_nxt = PH_BODY; do_wr = 1'b1;
          end
        end
        PH_SELECT: begin
          if (is_dig) begin
            acc_nxt = acc_dig; seen_nxt = 1'b1;
          end else if (!seen_r) begin
            ma = 1'b1; rm.kind = K_DONE; phase_nxt = PH_HALT;
          end else begin
            cc_nxt = acc_r; acc_nxt = '0; seen_nxt = 1'b0;
            phase_nxt = PH_BODY; do_body = 1'b1;
          end
        end
        default: ;
      endcase
    end

    // close an open header group; a pending number counts as a value
    if (do_close) begin
      if (seen_r) begin
        if (gcnt_r >= 3'd2 && gcnt_r <= 3'd4) gv_nxt[2'(gcnt_r - 3'd2)] = acc_r;
        if (gcnt_r != 3'd7) gcnt_nxt = gcnt_r + 3'd1;
      end
      if (!isc_r && gcnt_nxt == 3'd4) begin
        ga = 1'b1; rg.kind = K_SIZE;
        rg.width = 16'(gv_nxt[0]); rg.height = 16'(gv_nxt[1]);
      end else if (isc_r && gcnt_nxt == 3'd5) begin
        ga = 1'b1; rg.kind = K_PAL;
        rg.color_index = 16'(pc_r);
        rg.red = 16'(gv_nxt[0]); rg.green = 16'(gv_nxt[1]); rg.blue = 16'(gv_nxt[2]);
        if (pc_r != VMAX) pc_nxt = pc_r + val_t'(1);
      end
      acc_nxt = '0; seen_nxt = 1'b0; phase_nxt = PH_HEADER;
      if (in_data.stream_end) begin
        ma = 1'b1; rm.kind = K_DONE; phase_nxt = PH_HALT;
      end
    end

    if (do_hdr) begin
      if (b == CH_QUOTE || b == CH_HASH) begin
        isc_nxt = (b == CH_HASH);
        gcnt_nxt = '0;
        gv_nxt[0] = '0; gv_nxt[1] = '0; gv_nxt[2] = '0;
        acc_nxt = '0; seen_nxt = 1'b0;
        phase_nxt = PH_GROUP;
      end else begin
        phase_nxt = PH_BODY; do_body = 1'b1;
      end
    end

    if (do_body) begin
      case (b)
        CH_ESC:  phase_nxt = PH_BODY_ESC;
        CH_BANG: begin acc_nxt = '0; seen_nxt = 1'b0; phase_nxt = PH_REPEAT; end
        CH_HASH: begin acc_nxt = '0; seen_nxt = 1'b0; phase_nxt = PH_SELECT; end
        CH_DOLL: cx_nxt = '0;
        CH_DASH: begin
          cx_nxt = '0;
          sum = {1'b0, by_r} + (VALUE_BITS+1)'(BAND_H);
          by_nxt = sum[VALUE_BITS] ? VMAX : sum[VALUE_BITS-1:0];
        end
        default: begin
          if (is_dat) do_wr = 1'b1;
          else begin ma = 1'b1; rm.kind = K_DONE; phase_nxt = PH_HALT; end
        end
      endcase
    end

    // a select that ends on a data byte writes with the new color
    if (do_wr) begin
      ma = 1'b1; rm.kind = K_WRITE;
      rm.pos_x = 16'(cx_r); rm.pos_y = 16'(by_r);
      rm.mask = 6'(b - DATA_LO);
      rm.run_length = 16'(run); rm.color_index = 16'(cc_nxt);
      sum = {1'b0, cx_r} + {1'b0, run};
      cx_nxt = sum[VALUE_BITS] ? VMAX : sum[VALUE_BITS-1:0];
    end
  end

  always_comb begin
    res_n = {1'b0, ga} + {1'b0, ma};
    res0  = ga ? rg : rm;
    res1  = rm;
    res0.last = !(ga && ma);
    res1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_WAIT_ESC;
      acc_r   <= '0;
      seen_r  <= 1'b0;
      isc_r   <= 1'b0;
      gcnt_r  <= '0;
      gv_r    <= '{default: '0};
      cx_r    <= '0;
      by_r    <= '0;
      cc_r    <= '0;
      pc_r    <= '0;
    end else if (take) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      seen_r  <= seen_nxt;
      isc_r   <= isc_nxt;
      gcnt_r  <= gcnt_nxt;
      gv_r    <= gv_nxt;
      cx_r    <= cx_nxt;
      by_r    <= by_nxt;
      cc_r    <= cc_nxt;
      pc_r    <= pc_nxt;
    end
  end

endmodule

[sv/sxd_fifo.sv]
// ----------------------------------------------------------------------------
// Result queue
// Four-entry queue; takes up to two results a cycle, gives one.
// ----------------------------------------------------------------------------
module sxd_fifo import sxd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic [1:0] push_n,
  input  out_t       push0,
  input  out_t       push1,
  input  logic       pop,
  output logic       not_empty,
  output out_t       head,
  output fifo_stat_t stat
);

  out_t       mem [FIFO_DEPTH];
  logic [1:0] wp_r, wp_nxt;
  logic [1:0] rp_r, rp_nxt;
  logic [2:0] cnt_r, cnt_nxt;

  assign not_empty  = (cnt_r != 3'd0);
  assign head       = mem[rp_r];
  assign stat.count = cnt_r;

  always_comb begin
    wp_nxt  = wp_r + push_n;
    rp_nxt  = rp_r + {1'b0, pop};
    cnt_nxt = cnt_r + {1'b0, push_n} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem[wp_r] <= push0;
    if (push_n == 2'd2) mem[wp_r + 2'd1] <= push1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[sv/sixel_stream_decoder.sv]
// Output: results are decoded combinationally and registered in the queue.
// Throughput: one byte per cycle; the four-entry result queue accepts a new
// request while it holds at most two results (a byte yields up to two).
// Reset: rst_n synchronous, active low; parser back to waiting for ESC,
// queue emptied.
// ----------------------------------------------------------------------------
// Sixel stream decoder top level
// Byte-serial sixel parser with a result queue on the output side.
// ----------------------------------------------------------------------------
`include "sixel_stream_decoder_defines.svh"

module sixel_stream_decoder import sxd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic       take;
  logic [1:0] res_n;
  out_t       res0, res1;
  fifo_stat_t stat;

  assign in_ready = (stat.count <= 3'd2);
  assign take     = in_valid && in_ready;

  sxd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .take    (take),
    .in_data (in_data),
    .res_n   (res_n),
    .res0    (res0),
    .res1    (res1)
  );

  sxd_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_n    (take ? res_n : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .pop       (out_valid && out_ready),
    .not_empty (out_valid),
    .head      (out_data),
    .stat      (stat)
  );

  `SXD_CHECK(a_cnt_max, 1'b1, stat.count <= 3'd4, "result queue overfilled")
  `SXD_CHECK(a_ready_room, in_ready, stat.count <= 3'd2, "ready without room for two")
  `SXD_CHECK_NEXT(a_no_spurious, !in_valid && !out_valid, !out_valid, "result without request")

endmodule
